[rtl/ilmt_pkg.sv]
package ilmt_pkg;

    localparam int NUM_VECTORS_DEF = 32;
    localparam int NUM_LEVELS_DEF  = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [31:0] ALL_BLOCKED = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_UNMASK    = 2'd0,
        FUNC_MASK      = 2'd1,
        FUNC_SET_LEVEL = 2'd2,
        FUNC_INIT      = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_CLEAR_BIT,
        CMD_SET_BIT,
        CMD_LEVEL,
        CMD_INIT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [4:0]  bit_idx;
        logic [2:0]  count;
        logic [2:0]  level;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_DONE
    } t_back_state;

endpackage

[rtl/ilmt_front.sv]
module ilmt_front #(
    parameter int NUM_VECTORS = ilmt_pkg::NUM_VECTORS_DEF,
    parameter int NUM_LEVELS  = ilmt_pkg::NUM_LEVELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_func,
    input  logic [4:0]       i_vector,
    input  logic [2:0]       i_level,
    input  logic             i_q_ready,
    output logic             o_push,
    output ilmt_pkg::t_cmd   o_cmd
);

    localparam int VEC_IDX_W = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;

    logic [2:0]           r_vec_level [NUM_VECTORS];
    logic [VEC_IDX_W-1:0] vec_idx;
    logic                 vec_ok;
    logic                 lvl_ok;
    logic                 accept;
    logic [2:0]           rec_level;
    logic [2:0]           unmask_cnt;
    logic [2:0]           mask_cnt;
    ilmt_pkg::t_func      func;

    assign func    = ilmt_pkg::t_func'(i_func);
    assign vec_idx = VEC_IDX_W'({{VEC_IDX_W{1'b0}}, i_vector});
    assign vec_ok  = 32'(i_vector) < NUM_VECTORS;
    assign lvl_ok  = 32'(i_level) < NUM_LEVELS;
    assign accept  = i_valid && i_q_ready;
    assign o_ready = i_q_ready;
    assign o_push  = accept;

    assign rec_level  = r_vec_level[vec_idx];
    assign unmask_cnt = lvl_ok ? i_level : 3'(NUM_LEVELS);
    assign mask_cnt   = (32'(rec_level) < NUM_LEVELS) ? rec_level : 3'(NUM_LEVELS);

    always_comb begin
        o_cmd.kind    = ilmt_pkg::CMD_NOP;
        o_cmd.bit_idx = i_vector;
        o_cmd.count   = 3'd0;
        o_cmd.level   = i_level;
        case (func)
            ilmt_pkg::FUNC_UNMASK: begin
                if (vec_ok) begin
                    o_cmd.kind  = ilmt_pkg::CMD_CLEAR_BIT;
                    o_cmd.count = unmask_cnt;
                end
            end
            ilmt_pkg::FUNC_MASK: begin
                if (vec_ok) begin
                    o_cmd.kind  = ilmt_pkg::CMD_SET_BIT;
                    o_cmd.count = mask_cnt;
                end
            end
            ilmt_pkg::FUNC_SET_LEVEL: begin
                if (lvl_ok) begin
                    o_cmd.kind = ilmt_pkg::CMD_LEVEL;
                end
            end
            ilmt_pkg::FUNC_INIT: begin
                o_cmd.kind = ilmt_pkg::CMD_INIT;
            end
            default: begin
                o_cmd.kind = ilmt_pkg::CMD_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && func == ilmt_pkg::FUNC_INIT)) begin
            for (int i = 0; i < NUM_VECTORS; i++) begin
                r_vec_level[i] <= 3'd0;
            end
        end else if (accept && vec_ok && func == ilmt_pkg::FUNC_UNMASK) begin
            r_vec_level[vec_idx] <= i_level;
        end else if (accept && vec_ok && func == ilmt_pkg::FUNC_MASK) begin
            r_vec_level[vec_idx] <= 3'd0;
        end
    end

endmodule

[rtl/ilmt_queue.sv]
module ilmt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ilmt_pkg::t_cmd   i_cmd,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output ilmt_pkg::t_cmd   o_cmd
);

    localparam int DEPTH  = ilmt_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    ilmt_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= advance(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= advance(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/ilmt_back.sv]
module ilmt_back #(
    parameter int NUM_LEVELS = ilmt_pkg::NUM_LEVELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_pop,
    input  ilmt_pkg::t_cmd   i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_mask_out
);

    localparam int LVL_IDX_W = $clog2(NUM_LEVELS);

    ilmt_pkg::t_back_state r_state;
    ilmt_pkg::t_back_state n_state;
    ilmt_pkg::t_cmd        r_cmd;
    logic [2:0]            r_idx;
    logic [31:0]           r_masks [NUM_LEVELS];
    logic [2:0]            r_cur_level;
    logic                  r_out_valid;
    logic [31:0]           r_out_data;

    logic                  step;
    logic                  load;
    logic                  out_free;
    logic                  walk_needed;
    logic [LVL_IDX_W-1:0]  walk_idx;
    logic [LVL_IDX_W-1:0]  cur_idx;
    logic                  cur_ok;
    logic [31:0]           vec_bit;
    logic [31:0]           mask_word;

    assign out_free    = !r_out_valid || i_ready;
    assign walk_needed = (i_cmd.kind == ilmt_pkg::CMD_CLEAR_BIT
                          || i_cmd.kind == ilmt_pkg::CMD_SET_BIT)
                         && i_cmd.count != 3'd0;
    assign walk_idx    = LVL_IDX_W'({{LVL_IDX_W{1'b0}}, r_idx});
    assign cur_idx     = LVL_IDX_W'({{LVL_IDX_W{1'b0}}, r_cur_level});
    assign cur_ok      = 32'(r_cur_level) < NUM_LEVELS;
    assign vec_bit     = 32'd1 << r_cmd.bit_idx;
    assign mask_word   = cur_ok ? r_masks[cur_idx] : ilmt_pkg::ALL_BLOCKED;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ilmt_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = walk_needed ? ilmt_pkg::BK_WALK : ilmt_pkg::BK_DONE;
                end
            end
            ilmt_pkg::BK_WALK: begin
                if (r_idx == r_cmd.count - 3'd1) begin
                    n_state = ilmt_pkg::BK_DONE;
                end
            end
            ilmt_pkg::BK_DONE: begin
                if (out_free) begin
                    n_state = ilmt_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ilmt_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        step  = 1'b0;
        load  = 1'b0;
        case (r_state)
            ilmt_pkg::BK_IDLE: o_pop = i_q_valid;
            ilmt_pkg::BK_WALK: step  = 1'b1;
            ilmt_pkg::BK_DONE: load  = out_free;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ilmt_pkg::BK_IDLE;
            r_idx       <= 3'd0;
            r_cur_level <= 3'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_masks[i] <= ilmt_pkg::ALL_BLOCKED;
            end
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_idx <= 3'd0;
            end else if (step) begin
                r_idx <= r_idx + 3'd1;
            end
            if (o_pop && i_cmd.kind == ilmt_pkg::CMD_LEVEL) begin
                r_cur_level <= i_cmd.level;
            end else if (o_pop && i_cmd.kind == ilmt_pkg::CMD_INIT) begin
                r_cur_level <= 3'd0;
            end
            if (o_pop && i_cmd.kind == ilmt_pkg::CMD_INIT) begin
                for (int i = 0; i < NUM_LEVELS; i++) begin
                    r_masks[i] <= ilmt_pkg::ALL_BLOCKED;
                end
            end else if (step) begin
                if (r_cmd.kind == ilmt_pkg::CMD_CLEAR_BIT) begin
                    r_masks[walk_idx] <= r_masks[walk_idx] & ~vec_bit;
                end else begin
                    r_masks[walk_idx] <= r_masks[walk_idx] | vec_bit;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (load) begin
            r_out_data <= mask_word;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_mask_out = r_out_data;

endmodule

[rtl/interrupt_level_mask_table_top.sv]
// Interrupt priority level mask table.
// Input channel (i_valid / o_ready) carries one request: i_func selects unmask,
// mask, set current level or initialise; i_vector and i_level are its operands.
// Output channel (o_valid / i_ready) returns one o_mask_out word per request: the
// mask word of the current level once that request has taken effect.
// The front end classifies each request and keeps the per-vector levels; a
// two-entry queue hands commands to the back end, which owns the mask words.
// Unmask and mask walk one mask word per cycle over the levels below the vector's
// level (up to seven words); set-level and initialise skip the walk.
// The front accepts up to two further requests while the back end is busy.
// When the receiver stalls, the result is held in the output register and the
// back end holds its next command; once the queue fills, o_ready drops.
// Synchronous reset (i_rst_n low) sets every mask word to all ones, every vector
// level and the current level to zero, and empties the queue and output.
module interrupt_level_mask_table_top #(
    parameter int NUM_VECTORS = ilmt_pkg::NUM_VECTORS_DEF,
    parameter int NUM_LEVELS  = ilmt_pkg::NUM_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_vector,
    input  logic [2:0]  i_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_mask_out
);

    logic           q_ready;
    logic           push;
    ilmt_pkg::t_cmd push_cmd;
    logic           q_valid;
    logic           pop;
    ilmt_pkg::t_cmd pop_cmd;

    ilmt_front #(
        .NUM_VECTORS (NUM_VECTORS),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_func    (i_func),
        .i_vector  (i_vector),
        .i_level   (i_level),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    ilmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd)
    );

    ilmt_back #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_pop      (pop),
        .i_cmd      (pop_cmd),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_mask_out (o_mask_out)
    );

endmodule

[sim/interrupt_level_mask_table_top_test.sv]
`timescale 1ns / 100ps

module interrupt_level_mask_table_top_test;

    localparam int NUM_LEVELS  = ilmt_pkg::NUM_LEVELS_DEF;
    localparam int NUM_VECTORS = ilmt_pkg::NUM_VECTORS_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 16;

    typedef struct {
        ilmt_pkg::t_func func;
        logic [4:0]      vector;
        logic [2:0]      level;
        bit              drain_first;
    } t_request;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func   = ilmt_pkg::FUNC_UNMASK;
    logic [4:0]  i_vector = 5'd0;
    logic [2:0]  i_level  = 3'd0;
    logic        o_valid;
    logic        i_ready  = 1'b0;
    logic [31:0] o_mask_out;

    wire in_fire  = i_valid && o_ready;
    wire out_fire = o_valid && i_ready;

    t_request    pending_reqs[$];
    logic [31:0] expected_words[$];

    logic [2:0]  vec_level[NUM_VECTORS];
    logic [31:0] level_word[NUM_LEVELS];
    logic [2:0]  cur_level;

    int n_in;
    int n_out;
    int n_errors;
    int burst_left;
    int gap_left;
    int hold_left;
    bit hold_done;
    int phase_left;
    int stall_mode;
    int idle_cycles;

    interrupt_level_mask_table_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_vector   (i_vector),
        .i_level    (i_level),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_mask_out (o_mask_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void clear_table();
        for (int v = 0; v < NUM_VECTORS; v++) vec_level[v] = 3'd0;
        for (int l = 0; l < NUM_LEVELS; l++) level_word[l] = ilmt_pkg::ALL_BLOCKED;
        cur_level = 3'd0;
    endfunction

    function automatic logic [31:0] apply_request(ilmt_pkg::t_func f, logic [4:0] v,
                                                  logic [2:0] l);
        case (f)
            ilmt_pkg::FUNC_UNMASK: begin
                vec_level[v] = l;
                for (int i = 0; i < NUM_LEVELS; i++)
                    if (i < l) level_word[i][v] = 1'b0;
            end
            ilmt_pkg::FUNC_MASK: begin
                for (int i = 0; i < NUM_LEVELS; i++)
                    if (i < vec_level[v]) level_word[i][v] = 1'b1;
                vec_level[v] = 3'd0;
            end
            ilmt_pkg::FUNC_SET_LEVEL: begin
                if (l < NUM_LEVELS) cur_level = l;
            end
            default: begin
                clear_table();
            end
        endcase
        return level_word[cur_level];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch @%0t: %s, got %08h, want %08h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic add_request(ilmt_pkg::t_func f, logic [4:0] v, logic [2:0] l, bit drain);
        t_request r;
        r.func        = f;
        r.vector      = v;
        r.level       = l;
        r.drain_first = drain;
        pending_reqs.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            n_in       <= 0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (in_fire) begin
                expected_words.push_back(apply_request(ilmt_pkg::t_func'(i_func),
                                                       i_vector, i_level));
                n_in <= n_in + 1;
            end
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    i_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_reqs.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_reqs[0].drain_first
                             && (n_in + int'(in_fire)) != (n_out + int'(out_fire))) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid  <= 1'b1;
                    i_func   <= pending_reqs[0].func;
                    i_vector <= pending_reqs[0].vector;
                    i_level  <= pending_reqs[0].level;
                    pending_reqs.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            n_out      <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
            phase_left <= 0;
            stall_mode <= 0;
        end else begin
            if (out_fire) begin
                if (expected_words.size() == 0)
                    report_mismatch("result with no request outstanding", o_mask_out, 32'h0);
                else if (o_mask_out !== expected_words[0])
                    report_mismatch("mask_out", o_mask_out, expected_words[0]);
                if (expected_words.size() != 0) expected_words.pop_front();
                n_out <= n_out + 1;
            end
            if (hold_left != 0) begin
                i_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && n_out >= 400) begin
                i_ready   <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    phase_left <= $urandom_range(16, 96);
                    stall_mode <= $urandom_range(0, 2);
                end else begin
                    phase_left <= phase_left - 1;
                end
                case (stall_mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout @%0t", $time);
            $display("** interrupt_level_mask_table_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int              pick;
        ilmt_pkg::t_func f;

        n_errors = 0;
        clear_table();

        add_request(ilmt_pkg::FUNC_INIT,      5'd0,  3'd0, 1'b0);
        add_request(ilmt_pkg::FUNC_SET_LEVEL, 5'd0,  3'd0, 1'b0);
        add_request(ilmt_pkg::FUNC_UNMASK,    5'd0,  3'd7, 1'b0);
        add_request(ilmt_pkg::FUNC_UNMASK,    5'd31, 3'd1, 1'b0);
        add_request(ilmt_pkg::FUNC_UNMASK,    5'd5,  3'd0, 1'b0);
        add_request(ilmt_pkg::FUNC_SET_LEVEL, 5'd31, 3'd7, 1'b0);
        add_request(ilmt_pkg::FUNC_SET_LEVEL, 5'd0,  3'd6, 1'b0);
        add_request(ilmt_pkg::FUNC_MASK,      5'd0,  3'd7, 1'b0);
        add_request(ilmt_pkg::FUNC_SET_LEVEL, 5'd0,  3'd0, 1'b0);
        add_request(ilmt_pkg::FUNC_MASK,      5'd31, 3'd0, 1'b0);
        add_request(ilmt_pkg::FUNC_MASK,      5'd12, 3'd5, 1'b0);
        add_request(ilmt_pkg::FUNC_UNMASK,    5'd17, 3'd4, 1'b0);
        add_request(ilmt_pkg::FUNC_UNMASK,    5'd17, 3'd6, 1'b0);
        add_request(ilmt_pkg::FUNC_SET_LEVEL, 5'd0,  3'd5, 1'b0);
        add_request(ilmt_pkg::FUNC_MASK,      5'd17, 3'd0, 1'b0);
        add_request(ilmt_pkg::FUNC_UNMASK,    5'd31, 3'd7, 1'b0);
        add_request(ilmt_pkg::FUNC_UNMASK,    5'd10, 3'd3, 1'b0);
        add_request(ilmt_pkg::FUNC_SET_LEVEL, 5'd0,  3'd2, 1'b0);
        add_request(ilmt_pkg::FUNC_MASK,      5'd10, 3'd0, 1'b0);
        add_request(ilmt_pkg::FUNC_MASK,      5'd10, 3'd0, 1'b0);
        add_request(ilmt_pkg::FUNC_INIT,      5'd31, 3'd7, 1'b0);
        add_request(ilmt_pkg::FUNC_SET_LEVEL, 5'd0,  3'd1, 1'b0);

        for (int n = 0; n < 1530; n++) begin
            pick = $urandom_range(0, 199);
            if (pick < 85)       f = ilmt_pkg::FUNC_UNMASK;
            else if (pick < 155) f = ilmt_pkg::FUNC_MASK;
            else if (pick < 197) f = ilmt_pkg::FUNC_SET_LEVEL;
            else                 f = ilmt_pkg::FUNC_INIT;
            add_request(f, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                        n % 400 == 0);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || expected_words.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && expected_words.size() == 0) begin
            $display("** interrupt_level_mask_table_top: PASSED **");
        end else begin
            $display("** interrupt_level_mask_table_top: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ilmt_pkg.sv
rtl/ilmt_front.sv
rtl/ilmt_queue.sv
rtl/ilmt_back.sv
rtl/interrupt_level_mask_table_top.sv
sim/interrupt_level_mask_table_top_test.sv
